FILE: rtl/trb_pkg.sv
package trb_pkg;

  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_ROW0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_XOFF = 3'd3;
  localparam logic [IDX_W-1:0] REG_YOFF = 3'd4;
  localparam logic [IDX_W-1:0] REG_WOFF = 3'd5;

  localparam logic [63:0] ROW0_RESET = 64'h0001_0000_0000_0000;
  localparam logic [63:0] ROW1_RESET = 64'h0000_0000_0001_0000;
  localparam logic [63:0] ROW2_RESET = 64'h0;
  localparam logic [31:0] XOFF_RESET = 32'h0;
  localparam logic [31:0] YOFF_RESET = 32'h0;
  localparam logic [31:0] WOFF_RESET = 32'h0001_0000;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic flag;
  } ctl_t;

  // clip to signed 32, msb of the result is the clip flag
  function automatic logic [32:0] sat32(input logic [65:0] v);
    logic ovf;
    ovf = ~((&v[65:31]) | ~(|v[65:31]));
    if (ovf) begin
      return {1'b1, (v[65] ? S32_MIN : S32_MAX)};
    end
    return {1'b0, v[31:0]};
  endfunction

endpackage

FILE: rtl/trb_feed.sv
module trb_feed (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  rect_x,
  input  logic signed [31:0]  rect_y,
  input  logic signed [31:0]  rect_width,
  input  logic signed [31:0]  rect_height,
  output logic                busy,
  output trb_pkg::ctl_t       ctl,
  output logic signed [31:0]  cx,
  output logic signed [31:0]  cy
);

  logic        active;
  logic [1:0]  cnt;
  logic [31:0] hx0, hy0, hx1, hy1;
  logic        hflag;
  logic [32:0] sx, sy;
  logic [32:0] satx, saty;

  assign busy = active & (cnt != 2'd3);

  always_comb begin
    sx   = {rect_x[31], rect_x} + {rect_width[31], rect_width};
    sy   = {rect_y[31], rect_y} + {rect_height[31], rect_height};
    satx = trb_pkg::sat32({{33{sx[32]}}, sx});
    saty = trb_pkg::sat32({{33{sy[32]}}, sy});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      cnt       <= 2'd0;
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= active;
      if (start && !busy) begin
        active <= 1'b1;
        cnt    <= 2'd0;
      end else if (active) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          active <= 1'b0;
        end
      end
    end
    ctl.first <= (cnt == 2'd0);
    ctl.last  <= (cnt == 2'd3);
    ctl.flag  <= hflag;
    cx        <= cnt[0] ? hx1 : hx0;
    cy        <= cnt[1] ? hy1 : hy0;
    if (start && !busy) begin
      hx0   <= rect_x;
      hy0   <= rect_y;
      hx1   <= satx[31:0];
      hy1   <= saty[31:0];
      hflag <= satx[32] | saty[32];
    end
  end

endmodule

FILE: rtl/trb_rows.sv
module trb_rows #(
  parameter int FRAC_BITS = trb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  trb_pkg::ctl_t       ctl_in,
  input  logic signed [31:0]  cx,
  input  logic signed [31:0]  cy,
  input  logic [63:0]         row0,
  input  logic [63:0]         row1,
  input  logic [63:0]         row2,
  input  logic [31:0]         off_x,
  input  logic [31:0]         off_y,
  input  logic [31:0]         off_w,
  output trb_pkg::ctl_t       ctl_out,
  output logic signed [31:0]  xr,
  output logic signed [31:0]  yr,
  output logic signed [31:0]  wr
);

  logic signed [31:0] ca [3];
  logic signed [31:0] cb [3];
  logic [31:0]        cc [3];
  logic signed [63:0] pa [3];
  logic signed [63:0] pb [3];
  logic signed [64:0] sm [3];
  logic [32:0]        rs [3];
  trb_pkg::ctl_t      ctl_a, ctl_b;

  assign ca[0] = row0[63:32];
  assign cb[0] = row0[31:0];
  assign ca[1] = row1[63:32];
  assign cb[1] = row1[31:0];
  assign ca[2] = row2[63:32];
  assign cb[2] = row2[31:0];
  assign cc[0] = off_x;
  assign cc[1] = off_y;
  assign cc[2] = off_w;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rs[r] = trb_pkg::sat32({sm[r][64], sm[r]} + {{34{cc[r][31]}}, cc[r]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid   <= 1'b0;
      ctl_b.valid   <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_a.valid   <= ctl_in.valid;
      ctl_b.valid   <= ctl_a.valid;
      ctl_out.valid <= ctl_b.valid;
    end
    ctl_a.first <= ctl_in.first;
    ctl_a.last  <= ctl_in.last;
    ctl_a.flag  <= ctl_in.flag;
    ctl_b.first <= ctl_a.first;
    ctl_b.last  <= ctl_a.last;
    ctl_b.flag  <= ctl_a.flag;
    for (int r = 0; r < 3; r++) begin
      pa[r] <= ca[r] * cx;
      pb[r] <= cb[r] * cy;
      sm[r] <= ($signed({pa[r][63], pa[r]}) + $signed({pb[r][63], pb[r]})) >>> FRAC_BITS;
    end
    xr            <= rs[0][31:0];
    yr            <= rs[1][31:0];
    wr            <= rs[2][31:0];
    ctl_out.first <= ctl_b.first;
    ctl_out.last  <= ctl_b.last;
    ctl_out.flag  <= ctl_b.flag | rs[0][32] | rs[1][32] | rs[2][32];
  end

endmodule

FILE: rtl/trb_proj.sv
module trb_proj #(
  parameter int FRAC_BITS = trb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  trb_pkg::ctl_t       ctl_in,
  input  logic signed [31:0]  xr,
  input  logic signed [31:0]  yr,
  input  logic signed [31:0]  wr,
  output trb_pkg::ctl_t       ctl_out,
  output logic signed [31:0]  px,
  output logic signed [31:0]  py
);

  localparam int QW = 32;

  typedef struct packed {
    trb_pkg::ctl_t ctl;
    logic [63:0]   rx;
    logic [63:0]   ry;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [31:0]   d;
    logic          sx;
    logic          sy;
    logic          ovx;
    logic          ovy;
    logic          zero;
    logic [31:0]   rawx;
    logic [31:0]   rawy;
  } dstage_t;

  dstage_t     st [QW+1];
  dstage_t     pre;
  logic [31:0] nx, ny;
  logic [32:0] fx, fy;

  function automatic logic [32:0] fin(input logic [QW-1:0] q, input logic s,
                                      input logic ov);
    if (ov) begin
      return {1'b1, (s ? trb_pkg::S32_MIN : trb_pkg::S32_MAX)};
    end
    if (!s) begin
      if (q[31]) begin
        return {1'b1, trb_pkg::S32_MAX};
      end
      return {1'b0, q};
    end
    if (q > trb_pkg::S32_MIN) begin
      return {1'b1, trb_pkg::S32_MIN};
    end
    return {1'b0, 32'(-q)};
  endfunction

  always_comb begin
    nx       = xr[31] ? 32'(-xr) : xr;
    ny       = yr[31] ? 32'(-yr) : yr;
    pre.ctl  = ctl_in;
    pre.d    = wr[31] ? 32'(-wr) : wr;
    pre.rx   = {32'b0, nx} << FRAC_BITS;
    pre.ry   = {32'b0, ny} << FRAC_BITS;
    pre.qx   = '0;
    pre.qy   = '0;
    pre.sx   = xr[31] ^ wr[31];
    pre.sy   = yr[31] ^ wr[31];
    pre.ovx  = pre.rx >= {pre.d, 32'b0};
    pre.ovy  = pre.ry >= {pre.d, 32'b0};
    pre.zero = (wr == 32'sd0);
    pre.rawx = xr;
    pre.rawy = yr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].ctl.valid <= 1'b0;
    end else begin
      st[0] <= pre;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    localparam int B = QW - 1 - k;
    logic [63:0] dsh;
    dstage_t     nxt;
    always_comb begin
      dsh = {32'b0, st[k].d} << B;
      nxt = st[k];
      if (st[k].rx >= dsh) begin
        nxt.rx    = st[k].rx - dsh;
        nxt.qx[B] = 1'b1;
      end
      if (st[k].ry >= dsh) begin
        nxt.ry    = st[k].ry - dsh;
        nxt.qy[B] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].ctl.valid <= 1'b0;
      end else begin
        st[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    fx = fin(st[QW].qx, st[QW].sx, st[QW].ovx);
    fy = fin(st[QW].qy, st[QW].sy, st[QW].ovy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= st[QW].ctl.valid;
    end
    ctl_out.first <= st[QW].ctl.first;
    ctl_out.last  <= st[QW].ctl.last;
    if (st[QW].zero) begin
      px           <= st[QW].rawx;
      py           <= st[QW].rawy;
      ctl_out.flag <= st[QW].ctl.flag;
    end else begin
      px           <= fx[31:0];
      py           <= fy[31:0];
      ctl_out.flag <= st[QW].ctl.flag | fx[32] | fy[32];
    end
  end

endmodule

FILE: rtl/trb_bbox.sv
module trb_bbox (
  input  logic                clk,
  input  logic                rst,
  input  trb_pkg::ctl_t       ctl_in,
  input  logic signed [31:0]  cx,
  input  logic signed [31:0]  cy,
  output logic                done,
  output logic signed [31:0]  box_x,
  output logic signed [31:0]  box_y,
  output logic [30:0]         box_width,
  output logic [30:0]         box_height,
  output logic                saturated
);

  logic signed [31:0] minx, maxx, miny, maxy;
  logic               aflag;
  logic signed [31:0] nminx, nmaxx, nminy, nmaxy;
  logic               nflag;
  logic signed [31:0] fminx, fmaxx, fminy, fmaxy;
  logic               fflag, fvalid;
  logic [32:0]        bw, bh;

  always_comb begin
    if (ctl_in.first) begin
      nminx = cx;
      nmaxx = cx;
      nminy = cy;
      nmaxy = cy;
      nflag = ctl_in.flag;
    end else begin
      nminx = (cx < minx) ? cx : minx;
      nmaxx = (cx > maxx) ? cx : maxx;
      nminy = (cy < miny) ? cy : miny;
      nmaxy = (cy > maxy) ? cy : maxy;
      nflag = ctl_in.flag | aflag;
    end
    bw = {fmaxx[31], fmaxx} - {fminx[31], fminx};
    bh = {fmaxy[31], fmaxy} - {fminy[31], fminy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      fvalid <= ctl_in.valid & ctl_in.last;
      done   <= fvalid;
    end
    if (ctl_in.valid) begin
      minx  <= nminx;
      maxx  <= nmaxx;
      miny  <= nminy;
      maxy  <= nmaxy;
      aflag <= nflag;
    end
    fminx      <= nminx;
    fmaxx      <= nmaxx;
    fminy      <= nminy;
    fmaxy      <= nmaxy;
    fflag      <= nflag;
    box_x      <= fminx;
    box_y      <= fminy;
    box_width  <= (bw[32:31] != 2'b00) ? 31'h7fff_ffff : bw[30:0];
    box_height <= (bh[32:31] != 2'b00) ? 31'h7fff_ffff : bh[30:0];
    saturated  <= fflag | (bw[32:31] != 2'b00) | (bh[32:31] != 2'b00);
  end

endmodule

FILE: rtl/transform_rect_bounds.sv
// Maps a Q16.16 rectangle through a 3x3 projective matrix and returns the
// bounding box of its four mapped corners. The four corners go one per cycle
// through a shared multiply, row-sum and bit-per-stage divide pipeline, so a
// word can be taken again as the last corner of the one before goes out: busy
// is high after start is taken until that last corner is issued. done rises
// once the last corner has passed the row-sum, 32 divider stages and
// bounding-box registers, and is a one-cycle strobe that cannot be held off.
// Coefficient writes are only legal while no word is in flight.
module transform_rect_bounds #(
  parameter int FRAC_BITS = trb_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              rect_x,
  input  logic signed [31:0]              rect_y,
  input  logic signed [31:0]              rect_width,
  input  logic signed [31:0]              rect_height,
  output logic                            done,
  output logic signed [31:0]              box_x,
  output logic signed [31:0]              box_y,
  output logic [30:0]                     box_width,
  output logic [30:0]                     box_height,
  output logic                            saturated,
  input  logic                            cfg_we,
  input  logic [trb_pkg::IDX_W-1:0]       cfg_index,
  input  logic [63:0]                     cfg_data
);

  logic [63:0]        row0, row1, row2;
  logic [31:0]        off_x, off_y, off_w;
  trb_pkg::ctl_t      feed_ctl, rows_ctl, proj_ctl;
  logic signed [31:0] cx, cy, xr, yr, wr, px, py;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0  <= trb_pkg::ROW0_RESET;
      row1  <= trb_pkg::ROW1_RESET;
      row2  <= trb_pkg::ROW2_RESET;
      off_x <= trb_pkg::XOFF_RESET;
      off_y <= trb_pkg::YOFF_RESET;
      off_w <= trb_pkg::WOFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        trb_pkg::REG_ROW0: row0  <= cfg_data;
        trb_pkg::REG_ROW1: row1  <= cfg_data;
        trb_pkg::REG_ROW2: row2  <= cfg_data;
        trb_pkg::REG_XOFF: off_x <= cfg_data[31:0];
        trb_pkg::REG_YOFF: off_y <= cfg_data[31:0];
        trb_pkg::REG_WOFF: off_w <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  trb_feed u_feed (
    .clk, .rst, .start, .rect_x, .rect_y, .rect_width, .rect_height,
    .busy, .ctl(feed_ctl), .cx, .cy
  );

  trb_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk, .rst, .ctl_in(feed_ctl), .cx, .cy, .row0, .row1, .row2,
    .off_x, .off_y, .off_w, .ctl_out(rows_ctl), .xr, .yr, .wr
  );

  trb_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
    .clk, .rst, .ctl_in(rows_ctl), .xr, .yr, .wr,
    .ctl_out(proj_ctl), .px, .py
  );

  trb_bbox u_bbox (
    .clk, .rst, .ctl_in(proj_ctl), .cx(px), .cy(py),
    .done, .box_x, .box_y, .box_width, .box_height, .saturated
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_busy_len: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> ##1 busy ##1 busy ##1 !busy)
    else $error("busy window not three cycles");

  a_corner_run: assert property (@(posedge clk) disable iff (rst)
    (feed_ctl.valid && feed_ctl.first) |=> (feed_ctl.valid && !feed_ctl.first))
    else $error("corner run broken");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (proj_ctl.valid && proj_ctl.last) |=> ##1 done)
    else $error("last corner gave no result");
`endif

endmodule
